@@ design/eight_bit_alu_with_flags_macros.svh @@
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_macros.svh
// Assertion macros used by the checker file of the ALU block.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ALU8F_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ALU8F assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ALU8F_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ALU8F assertion failed");

`endif

@@ design/alu8f_pkg.sv @@
// ----------------------------------------------------------------------------
// alu8f_pkg
// Types, operation codes and constants of the eight-bit ALU with flags.
// ----------------------------------------------------------------------------
package alu8f_pkg;

    typedef enum logic [5:0] {
        OP_ADD   = 6'd0,
        OP_ADC   = 6'd1,
        OP_SUB   = 6'd2,
        OP_SBC   = 6'd3,
        OP_AND   = 6'd4,
        OP_XOR   = 6'd5,
        OP_OR    = 6'd6,
        OP_CP    = 6'd7,
        OP_RLC   = 6'd8,
        OP_RRC   = 6'd9,
        OP_RL    = 6'd10,
        OP_RR    = 6'd11,
        OP_SLA   = 6'd12,
        OP_SRA   = 6'd13,
        OP_SWAP  = 6'd14,
        OP_SRL   = 6'd15,
        OP_BIT   = 6'd16,
        OP_RES   = 6'd17,
        OP_SET   = 6'd18,
        OP_RLCA  = 6'd19,
        OP_RRCA  = 6'd20,
        OP_RLA   = 6'd21,
        OP_RRA   = 6'd22,
        OP_INC   = 6'd23,
        OP_DEC   = 6'd24,
        OP_DAA   = 6'd25,
        OP_CPL   = 6'd26,
        OP_SCF   = 6'd27,
        OP_CCF   = 6'd28,
        OP_ADD16 = 6'd29,
        OP_ADDSP = 6'd30,
        OP_LDA   = 6'd31,
        OP_LDAF  = 6'd32
    } t_op;

    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } t_shift;

    localparam logic [2:0] ACC_ROT_BASE = 3'd3;
    localparam logic [7:0] DAA_LIMIT    = 8'h99;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    typedef struct packed {
        logic [5:0]  operation;
        logic [7:0]  operand_value;
        logic [2:0]  bit_index;
        logic [15:0] wide_first;
        logic [15:0] wide_second;
    } t_alu_req;

    typedef struct packed {
        logic [7:0]  byte_result;
        logic [15:0] word_result;
        logic [7:0]  accumulator_out;
        logic        zero_flag;
        logic        subtract_flag;
        logic        half_carry_flag;
        logic        carry_flag;
    } t_alu_res;

endpackage

@@ design/alu8f_core.sv @@
// ----------------------------------------------------------------------------
// alu8f_core
// Single-pass datapath: computes the result, new accumulator and new flags of
// one request from the current accumulator and flags.
// ----------------------------------------------------------------------------
module alu8f_core (
    input  alu8f_pkg::t_alu_req i_req,
    input  logic [7:0]          i_acc,
    input  alu8f_pkg::t_flags   i_flags,
    output alu8f_pkg::t_alu_res o_res
);

    function automatic logic [8:0] shift_op(input logic [2:0] k, input logic [7:0] x,
                                            input logic cin);
        logic [8:0] r;
        case (k)
            alu8f_pkg::SH_RLC:  r = {x[7], x[6:0], x[7]};
            alu8f_pkg::SH_RRC:  r = {x[0], x[0], x[7:1]};
            alu8f_pkg::SH_RL:   r = {x[7], x[6:0], cin};
            alu8f_pkg::SH_RR:   r = {x[0], cin, x[7:1]};
            alu8f_pkg::SH_SLA:  r = {x[7], x[6:0], 1'b0};
            alu8f_pkg::SH_SRA:  r = {x[0], x[7], x[7:1]};
            alu8f_pkg::SH_SWAP: r = {1'b0, x[3:0], x[7:4]};
            default:            r = {x[0], 1'b0, x[7:1]};
        endcase
        return r;
    endfunction

    logic [5:0]  op;
    logic [7:0]  a;
    logic [7:0]  v;
    logic [15:0] w1;
    logic [15:0] w2;
    logic        ci;
    logic [8:0]  add9;
    logic [4:0]  add_h5;
    logic [8:0]  sub9;
    logic [4:0]  sub_h5;
    logic        acc_rot;
    logic [2:0]  sh_k;
    logic [8:0]  sh_r;
    logic [7:0]  bit_mask;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic        daa_hi;
    logic [7:0]  daa_a1;
    logic [7:0]  daa_a2;
    logic [16:0] add17;
    logic [12:0] add_h13;
    logic [15:0] sp_sum;
    logic [8:0]  sp_c9;
    logic [4:0]  sp_h5;
    logic [7:0]  acc_n;
    alu8f_pkg::t_flags flg_n;
    logic [7:0]  byte_r;
    logic [15:0] word_r;

    assign op = i_req.operation;
    assign a  = i_acc;
    assign v  = i_req.operand_value;
    assign w1 = i_req.wide_first;
    assign w2 = i_req.wide_second;

    assign ci = ((op == alu8f_pkg::OP_ADC) || (op == alu8f_pkg::OP_SBC)) ? i_flags.c : 1'b0;
    assign add9   = {1'b0, a} + {1'b0, v} + {8'd0, ci};
    assign add_h5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, ci};
    assign sub9   = {1'b0, a} - {1'b0, v} - {8'd0, ci};
    assign sub_h5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, ci};

    assign acc_rot = op inside {[alu8f_pkg::OP_RLCA:alu8f_pkg::OP_RRA]};
    assign sh_k    = acc_rot ? (op[2:0] - alu8f_pkg::ACC_ROT_BASE) : op[2:0];
    assign sh_r    = shift_op(sh_k, acc_rot ? a : v, i_flags.c);

    assign bit_mask = 8'h01 << i_req.bit_index;
    assign inc8     = v + 8'd1;
    assign dec8     = v - 8'd1;

    always_comb begin
        daa_hi = i_flags.c || (a > alu8f_pkg::DAA_LIMIT);
        if (!i_flags.n) begin
            daa_a1 = daa_hi ? (a + alu8f_pkg::DAA_HI_ADJ) : a;
            daa_a2 = (i_flags.h || (daa_a1[3:0] > alu8f_pkg::DAA_LO_LIMIT))
                   ? (daa_a1 + alu8f_pkg::DAA_LO_ADJ) : daa_a1;
        end else begin
            daa_a1 = i_flags.c ? (a - alu8f_pkg::DAA_HI_ADJ) : a;
            daa_a2 = i_flags.h ? (daa_a1 - alu8f_pkg::DAA_LO_ADJ) : daa_a1;
        end
    end

    assign add17   = {1'b0, w1} + {1'b0, w2};
    assign add_h13 = {1'b0, w1[11:0]} + {1'b0, w2[11:0]};
    assign sp_sum  = w1 + {{8{v[7]}}, v};
    assign sp_c9   = {1'b0, w1[7:0]} + {1'b0, v};
    assign sp_h5   = {1'b0, w1[3:0]} + {1'b0, v[3:0]};

    always_comb begin
        acc_n  = a;
        flg_n  = i_flags;
        byte_r = 8'd0;
        word_r = 16'd0;
        case (op)
            alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
                acc_n = add9[7:0];
                flg_n = '{z: (add9[7:0] == 8'd0), n: 1'b0, h: add_h5[4], c: add9[8]};
            end
            alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC, alu8f_pkg::OP_CP: begin
                if (op != alu8f_pkg::OP_CP) begin
                    acc_n = sub9[7:0];
                end
                flg_n = '{z: (sub9[7:0] == 8'd0), n: 1'b1, h: sub_h5[4], c: sub9[8]};
            end
            alu8f_pkg::OP_AND: begin
                acc_n = a & v;
                flg_n = '{z: ((a & v) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            alu8f_pkg::OP_XOR: begin
                acc_n = a ^ v;
                flg_n = '{z: ((a ^ v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            alu8f_pkg::OP_OR: begin
                acc_n = a | v;
                flg_n = '{z: ((a | v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            alu8f_pkg::OP_RLC, alu8f_pkg::OP_RRC, alu8f_pkg::OP_RL, alu8f_pkg::OP_RR,
            alu8f_pkg::OP_SLA, alu8f_pkg::OP_SRA, alu8f_pkg::OP_SWAP,
            alu8f_pkg::OP_SRL: begin
                byte_r = sh_r[7:0];
                flg_n  = '{z: (sh_r[7:0] == 8'd0), n: 1'b0, h: 1'b0, c: sh_r[8]};
            end
            alu8f_pkg::OP_RLCA, alu8f_pkg::OP_RRCA, alu8f_pkg::OP_RLA,
            alu8f_pkg::OP_RRA: begin
                acc_n = sh_r[7:0];
                flg_n = '{z: 1'b0, n: 1'b0, h: 1'b0, c: sh_r[8]};
            end
            alu8f_pkg::OP_BIT: begin
                flg_n.z = ((v & bit_mask) == 8'd0);
                flg_n.n = 1'b0;
                flg_n.h = 1'b1;
            end
            alu8f_pkg::OP_RES: begin
                byte_r = v & ~bit_mask;
            end
            alu8f_pkg::OP_SET: begin
                byte_r = v | bit_mask;
            end
            alu8f_pkg::OP_INC: begin
                byte_r  = inc8;
                flg_n.z = (inc8 == 8'd0);
                flg_n.n = 1'b0;
                flg_n.h = (v[3:0] == 4'hF);
            end
            alu8f_pkg::OP_DEC: begin
                byte_r  = dec8;
                flg_n.z = (dec8 == 8'd0);
                flg_n.n = 1'b1;
                flg_n.h = (v[3:0] == 4'h0);
            end
            alu8f_pkg::OP_DAA: begin
                acc_n   = daa_a2;
                flg_n.z = (daa_a2 == 8'd0);
                flg_n.h = 1'b0;
                if (!i_flags.n && daa_hi) begin
                    flg_n.c = 1'b1;
                end
            end
            alu8f_pkg::OP_CPL: begin
                acc_n   = ~a;
                flg_n.n = 1'b1;
                flg_n.h = 1'b1;
            end
            alu8f_pkg::OP_SCF: begin
                flg_n.n = 1'b0;
                flg_n.h = 1'b0;
                flg_n.c = 1'b1;
            end
            alu8f_pkg::OP_CCF: begin
                flg_n.n = 1'b0;
                flg_n.h = 1'b0;
                flg_n.c = ~i_flags.c;
            end
            alu8f_pkg::OP_ADD16: begin
                word_r  = add17[15:0];
                flg_n.n = 1'b0;
                flg_n.h = add_h13[12];
                flg_n.c = add17[16];
            end
            alu8f_pkg::OP_ADDSP: begin
                word_r = sp_sum;
                flg_n  = '{z: 1'b0, n: 1'b0, h: sp_h5[4], c: sp_c9[8]};
            end
            alu8f_pkg::OP_LDA: begin
                acc_n = v;
            end
            alu8f_pkg::OP_LDAF: begin
                acc_n = w1[15:8];
                flg_n = '{z: w1[7], n: w1[6], h: w1[5], c: w1[4]};
            end
            default: begin
                acc_n = a;
            end
        endcase
    end

    assign o_res.byte_result     = byte_r;
    assign o_res.word_result     = word_r;
    assign o_res.accumulator_out = acc_n;
    assign o_res.zero_flag       = flg_n.z;
    assign o_res.subtract_flag   = flg_n.n;
    assign o_res.half_carry_flag = flg_n.h;
    assign o_res.carry_flag      = flg_n.c;

endmodule

@@ design/eight_bit_alu_with_flags.sv @@
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags
// Accumulator, flag register and ALU of an eight-bit CPU core.
//
// Usage:
// A request enters on the input channel (i_in_valid, o_in_stall, i_in_data)
// and names one operation with its operands. The block answers every request
// with exactly one result on the output channel (o_out_valid, i_out_stall,
// o_out_data), in request order. The result carries the byte and word
// results and the accumulator and flags after the operation.
// The request is first held in the input register; then one ALU pass loads
// the result register and the state.
// Throughput is one request per cycle while the receiver does not stall; the
// ALU pass is the only logic stage and each request sees the state left by
// the one before it.
// While the receiver stalls, the result holds, the request in the input
// register waits, and o_in_stall rises once both registers are full.
// Reset clears the accumulator, the flags and both valid bits.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  alu8f_pkg::t_alu_req i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output alu8f_pkg::t_alu_res o_out_data
);

    logic                r_req_valid;
    alu8f_pkg::t_alu_req r_req;
    logic                r_res_valid;
    alu8f_pkg::t_alu_res r_res;
    logic [7:0]          r_acc;
    alu8f_pkg::t_flags   r_flags;
    alu8f_pkg::t_alu_res n_res;
    logic                res_free;
    logic                req_move;
    logic                req_take;

    assign res_free = !r_res_valid || !i_out_stall;
    assign req_move = r_req_valid && res_free;
    assign req_take = i_in_valid && !o_in_stall;

    assign o_in_stall  = r_req_valid && !res_free;
    assign o_out_valid = r_res_valid;
    assign o_out_data  = r_res;

    alu8f_core u_core (
        .i_req   (r_req),
        .i_acc   (r_acc),
        .i_flags (r_flags),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_res_valid <= 1'b0;
            r_acc       <= 8'd0;
            r_flags     <= '0;
        end else begin
            if (req_take) begin
                r_req_valid <= 1'b1;
            end else if (req_move) begin
                r_req_valid <= 1'b0;
            end
            if (req_move) begin
                r_res_valid <= 1'b1;
                r_acc       <= n_res.accumulator_out;
                r_flags     <= '{z: n_res.zero_flag, n: n_res.subtract_flag,
                                 h: n_res.half_carry_flag, c: n_res.carry_flag};
            end else if (res_free) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_req <= i_in_data;
        end
        if (req_move) begin
            r_res <= n_res;
        end
    end

endmodule

@@ design/alu8f_checker.sv @@
// ----------------------------------------------------------------------------
// alu8f_checker
// Port-level checks of the ALU block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "eight_bit_alu_with_flags_macros.svh"

module alu8f_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input alu8f_pkg::t_alu_req i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input alu8f_pkg::t_alu_res o_out_data
);

    logic in_take;

    assign in_take = i_in_valid && !o_in_stall;

    // A stalled result stays valid.
    `ALU8F_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // A stalled result does not change.
    `ALU8F_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

    // The input side only stalls while a result is held up by the receiver.
    `ALU8F_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // An accepted request passes through the input register and reaches the output when the receiver does not stall.
    `ALU8F_ASSERT_NEXT(a_latency, i_clk, i_rst_n, in_take ##1 !i_out_stall, o_out_valid)

endmodule

bind eight_bit_alu_with_flags alu8f_checker u_alu8f_checker (.*);

@@ verif/eight_bit_alu_with_flags_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_tb
// Self-checking testbench of the eight-bit ALU with flags.
//
// A scoreboard keeps its own copy of the accumulator and flags, predicts the
// result of every accepted request and compares each result field by field,
// in order. Stimulus is a directed pass over every operation with extreme
// operands and the flag corner cases, then random requests. Most random
// requests are single operations; some are BCD add or subtract sequences
// ending in DAA, and some load AF first to reach arbitrary flag states.
// Both channels idle at random, and the sender drains the block now and then.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_tb;
    import alu8f_pkg::*;

    localparam logic [5:0] OP_UNUSED_TOP = 6'h3F;
    localparam int         RANDOM_ITEMS  = 1750;
    localparam int         DRAIN_EVERY   = 500;

    class alu_scoreboard;
        t_alu_res   expected_q[$];
        logic [7:0] acc_state;
        t_flags     flag_state;
        int         error_count;
        int         checked_count;
        int         daa_count;

        function new();
            acc_state     = 8'h00;
            flag_state    = '0;
            error_count   = 0;
            checked_count = 0;
            daa_count     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(t_alu_req rq);
            logic [7:0]  a;
            logic [7:0]  v;
            logic [7:0]  x;
            logic [7:0]  t;
            logic [7:0]  br;
            logic [15:0] wr;
            logic [15:0] ext;
            logic [8:0]  sum9;
            logic [16:0] sum17;
            logic [5:0]  d;
            logic        z, n, h, c, cin, ci, acc_form;
            t_shift      k;
            t_alu_res    res;

            a   = acc_state;
            v   = rq.operand_value;
            {z, n, h, c} = flag_state;
            cin = flag_state.c;
            br  = 8'h00;
            wr  = 16'h0000;
            case (rq.operation)
                OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP: begin
                    ci = (rq.operation == OP_ADC || rq.operation == OP_SBC) ? cin : 1'b0;
                    if (rq.operation == OP_ADD || rq.operation == OP_ADC) begin
                        sum9 = {1'b0, a} + {1'b0, v} + ci;
                        h    = ({1'b0, a[3:0]} + {1'b0, v[3:0]} + ci) > 5'h0F;
                        c    = sum9[8];
                        n    = 1'b0;
                    end else begin
                        sum9 = {1'b0, a} - {1'b0, v} - ci;
                        h    = {1'b0, a[3:0]} < ({1'b0, v[3:0]} + ci);
                        c    = {1'b0, a} < ({1'b0, v} + ci);
                        n    = 1'b1;
                    end
                    t = sum9[7:0];
                    z = (t == 8'h00);
                    if (rq.operation != OP_CP) a = t;
                end
                OP_AND: begin
                    a = a & v;
                    {z, n, h, c} = {a == 8'h00, 1'b0, 1'b1, 1'b0};
                end
                OP_XOR: begin
                    a = a ^ v;
                    {z, n, h, c} = {a == 8'h00, 3'b000};
                end
                OP_OR: begin
                    a = a | v;
                    {z, n, h, c} = {a == 8'h00, 3'b000};
                end
                OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
                OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
                    acc_form = (rq.operation >= OP_RLCA);
                    x = acc_form ? a : v;
                    d = acc_form ? rq.operation - OP_RLCA : rq.operation - OP_RLC;
                    k = t_shift'(d[2:0]);
                    case (k)
                        SH_RLC:  begin c = x[7]; t = {x[6:0], x[7]}; end
                        SH_RRC:  begin c = x[0]; t = {x[0], x[7:1]}; end
                        SH_RL:   begin c = x[7]; t = {x[6:0], cin}; end
                        SH_RR:   begin c = x[0]; t = {cin, x[7:1]}; end
                        SH_SLA:  begin c = x[7]; t = {x[6:0], 1'b0}; end
                        SH_SRA:  begin c = x[0]; t = {x[7], x[7:1]}; end
                        SH_SWAP: begin c = 1'b0; t = {x[3:0], x[7:4]}; end
                        default: begin c = x[0]; t = {1'b0, x[7:1]}; end
                    endcase
                    n = 1'b0;
                    h = 1'b0;
                    if (acc_form) begin
                        a = t;
                        z = 1'b0;
                    end else begin
                        br = t;
                        z  = (t == 8'h00);
                    end
                end
                OP_BIT: begin
                    z = !v[rq.bit_index];
                    n = 1'b0;
                    h = 1'b1;
                end
                OP_RES: br = v & ~(8'h01 << rq.bit_index);
                OP_SET: br = v | (8'h01 << rq.bit_index);
                OP_INC: begin
                    h  = (v[3:0] == 4'hF);
                    br = v + 8'h01;
                    z  = (br == 8'h00);
                    n  = 1'b0;
                end
                OP_DEC: begin
                    h  = (v[3:0] == 4'h0);
                    br = v - 8'h01;
                    z  = (br == 8'h00);
                    n  = 1'b1;
                end
                OP_DAA: begin
                    if (!n) begin
                        if (c || a > 8'h99) begin
                            a = a + 8'h60;
                            c = 1'b1;
                        end
                        if (h || a[3:0] > 4'h9) a = a + 8'h06;
                    end else begin
                        if (c) a = a - 8'h60;
                        if (h) a = a - 8'h06;
                    end
                    z = (a == 8'h00);
                    h = 1'b0;
                    daa_count++;
                end
                OP_CPL: begin
                    a = ~a;
                    n = 1'b1;
                    h = 1'b1;
                end
                OP_SCF: {n, h, c} = 3'b001;
                OP_CCF: {n, h, c} = {2'b00, !cin};
                OP_ADD16: begin
                    sum17 = {1'b0, rq.wide_first} + {1'b0, rq.wide_second};
                    h  = ({1'b0, rq.wide_first[11:0]} + {1'b0, rq.wide_second[11:0]})
                         > 13'h0FFF;
                    c  = sum17[16];
                    n  = 1'b0;
                    wr = sum17[15:0];
                end
                OP_ADDSP: begin
                    ext = {{8{v[7]}}, v};
                    h  = ({1'b0, rq.wide_first[3:0]} + {1'b0, v[3:0]}) > 5'h0F;
                    c  = ({1'b0, rq.wide_first[7:0]} + {1'b0, v}) > 9'h0FF;
                    z  = 1'b0;
                    n  = 1'b0;
                    wr = rq.wide_first + ext;
                end
                OP_LDA:  a = v;
                OP_LDAF: begin
                    a = rq.wide_first[15:8];
                    {z, n, h, c} = rq.wide_first[7:4];
                end
                default: ;
            endcase

            acc_state  = a;
            flag_state = {z, n, h, c};
            res.byte_result     = br;
            res.word_result     = wr;
            res.accumulator_out = a;
            res.zero_flag       = z;
            res.subtract_flag   = n;
            res.half_carry_flag = h;
            res.carry_flag      = c;
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            error_count++;
            $display("%0t ns: mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
                     $time, checked_count, what, got, want);
        endtask

        task check_result(t_alu_res got);
            t_alu_res want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no request waiting", 16'h0, 16'h0);
            end else begin
                want = expected_q.pop_front();
                if (got.byte_result !== want.byte_result)
                    report_mismatch("byte_result", got.byte_result, want.byte_result);
                if (got.word_result !== want.word_result)
                    report_mismatch("word_result", got.word_result, want.word_result);
                if (got.accumulator_out !== want.accumulator_out)
                    report_mismatch("accumulator_out", got.accumulator_out,
                                    want.accumulator_out);
                if (got.zero_flag !== want.zero_flag)
                    report_mismatch("zero_flag", got.zero_flag, want.zero_flag);
                if (got.subtract_flag !== want.subtract_flag)
                    report_mismatch("subtract_flag", got.subtract_flag, want.subtract_flag);
                if (got.half_carry_flag !== want.half_carry_flag)
                    report_mismatch("half_carry_flag", got.half_carry_flag,
                                    want.half_carry_flag);
                if (got.carry_flag !== want.carry_flag)
                    report_mismatch("carry_flag", got.carry_flag, want.carry_flag);
            end
            checked_count++;
        endtask
    endclass

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_alu_req i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_alu_res o_out_data;

    alu_scoreboard sb = new();
    int            sent_count     = 0;
    int            directed_count = 0;

    eight_bit_alu_with_flags dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_alu_req make_request(logic [5:0] op, logic [7:0] v, logic [2:0] bi,
                                              logic [15:0] w1, logic [15:0] w2);
        t_alu_req rq;
        rq.operation     = op;
        rq.operand_value = v;
        rq.bit_index     = bi;
        rq.wide_first    = w1;
        rq.wide_second   = w2;
        return rq;
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7F;
            3: return ($urandom_range(0, 1) != 0) ? 8'h0F : 8'h10;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return ($urandom_range(0, 1) != 0) ? 16'h0FFF : 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] random_bcd();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    task automatic send_request(t_alu_req rq);
        i_in_valid <= 1'b1;
        i_in_data  <= rq;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(rq);
        sent_count++;
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic issue(t_alu_req rq);
        send_request(rq);
        pause_sender(idle_len());
    endtask

    task automatic drain_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic issue_random_single();
        logic [5:0] op;
        if ($urandom_range(0, 9) == 0)
            op = 6'($urandom_range(OP_LDAF + 1, OP_UNUSED_TOP));
        else
            op = 6'($urandom_range(OP_ADD, OP_LDAF));
        issue(make_request(op, random_byte(), 3'($urandom_range(0, 7)),
                           random_word(), random_word()));
    endtask

    // A BCD operand pair through add or subtract, then the decimal adjust.
    task automatic issue_bcd_sequence();
        logic [5:0] op;
        case ($urandom_range(0, 3))
            0: op = OP_ADD;
            1: op = OP_ADC;
            2: op = OP_SUB;
            default: op = OP_SBC;
        endcase
        issue(make_request(OP_LDA, random_bcd(), 3'd0, 16'h0000, 16'h0000));
        issue(make_request(op, random_bcd(), 3'd0, 16'h0000, 16'h0000));
        issue(make_request(OP_DAA, random_byte(), 3'd0, random_word(), random_word()));
    endtask

    task automatic run_directed();
        logic [7:0] v;
        // Flags come from the high nibble of the low byte only.
        issue(make_request(OP_LDAF, 8'h00, 3'd0, 16'h99FF, 16'h0000));
        // Adjust with the subtract flag and both carries set.
        issue(make_request(OP_DAA, 8'h00, 3'd0, 16'h0000, 16'h0000));
        // Adjust with the subtract flag clear and the accumulator above 0x99.
        issue(make_request(OP_LDA, 8'h9A, 3'd0, 16'h0000, 16'h0000));
        issue(make_request(OP_OR, 8'h00, 3'd0, 16'h0000, 16'h0000));
        issue(make_request(OP_DAA, 8'h00, 3'd0, 16'h0000, 16'h0000));
        for (int op = OP_ADD; op <= OP_LDAF; op++) begin
            case (op % 4)
                0: v = 8'hFF;
                1: v = 8'h00;
                2: v = 8'h80;
                default: v = 8'h7F;
            endcase
            issue(make_request(6'(op), v, 3'(op), 16'hFFFF, 16'h0001));
        end
        issue(make_request(OP_ADDSP, 8'h01, 3'd0, 16'h000F, 16'h0000));
        issue(make_request(OP_ADD16, 8'h00, 3'd0, 16'h0800, 16'h0800));
        issue(make_request(OP_UNUSED_TOP, 8'hFF, 3'd7, 16'hFFFF, 16'hFFFF));
        directed_count = sent_count;
    endtask

    initial begin
        int next_drain;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain_block();

        next_drain = sent_count + DRAIN_EVERY;
        while (sent_count < directed_count + RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2: issue_bcd_sequence();
                3: begin
                    issue(make_request(OP_LDAF, random_byte(), 3'd0, random_word(),
                                       random_word()));
                    issue_random_single();
                end
                default: issue_random_single();
            endcase
            if (sent_count >= next_drain) begin
                drain_block();
                next_drain = sent_count + DRAIN_EVERY;
            end
        end

        drain_block();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d requests (%0d directed) over every operation and unknown codes,",
                 sent_count, directed_count);
        $display("with %0d decimal adjusts; %0d results checked.",
                 sb.daa_count, sb.checked_count);
        if (sb.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        int run_len;
        int stall_len;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 9) == 0)
                run_len = $urandom_range(50, 200);
            else
                run_len = $urandom_range(1, 6);
            repeat (run_len) @(posedge i_clk);
            stall_len = idle_len();
            if (stall_len == 0) stall_len = 1;
            i_out_stall <= 1'b1;
            repeat (stall_len) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
        end
    end

    initial begin
        #10ms;
        $display("Timeout with %0d results still expected.", sb.pending());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
